@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, switched off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/fkr_pkg.sv @@
// ----------------------------------------------------------------------------
// fkr_pkg
// Shared types and constants for the keyed-removal process queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fkr_pkg;

    // Default number of entries held
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // One queue entry as kept in the store
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

endpackage

@@ sv/fifo_with_keyed_removal.sv @@
// ----------------------------------------------------------------------------
// fifo_with_keyed_removal
// Bounded process queue: push at tail, pop head, remove first entry by key.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  input    | in_valid / in_stall   | op, proc_key, proc_handle
//  output   | out_valid / out_stall | out_key, out_handle, status, entry_count
//
//  Entries sit in a circular buffer; one memory port pair and one key
//  comparator are stepped by a small sequencer, at most one read per step.
//  Push, no-op, full and empty cases go straight to the result step; pop
//  reads the head entry. Removal scans from the head, then closes the gap,
//  moving each later entry one place toward the head; removal at the head
//  skips the shift. in_stall is high from an accepted transfer until its
//  result is registered. A stalled result holds in the output register;
//  the next item may be taken while it waits. Reset clears all but memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_with_keyed_removal #(
    parameter int QUEUE_DEPTH = fkr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fkr_pkg::OP_W-1:0]      op,
    input  logic [fkr_pkg::KEY_W-1:0]     proc_key,
    input  logic [fkr_pkg::HANDLE_W-1:0]  proc_handle,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fkr_pkg::KEY_W-1:0]     out_key,
    output logic [fkr_pkg::HANDLE_W-1:0]  out_handle,
    output logic [fkr_pkg::STATUS_W-1:0]  status,
    output logic [fkr_pkg::COUNT_W-1:0]   entry_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    fkr_pkg::op_t                  op_reg, op_next;
    logic [fkr_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [fkr_pkg::KEY_W-1:0]     res_key_reg, res_key_next;
    logic [fkr_pkg::HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    fkr_pkg::status_t              res_status_reg, res_status_next;
    logic                          out_valid_reg, out_valid_next;
    logic [fkr_pkg::KEY_W-1:0]     out_key_reg, out_key_next;
    logic [fkr_pkg::HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    fkr_pkg::status_t              out_status_reg, out_status_next;
    logic [fkr_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;

    // store ports
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    fkr_pkg::entry_t wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    fkr_pkg::entry_t rd_data;

    // helpers
    logic [SW-1:0]   tail_sum;
    logic [AW-1:0]   tail_addr;
    logic [AW-1:0]   addr_inc;
    logic [AW-1:0]   head_inc;
    logic            last_scan;
    logic            last_move;
    logic            hit;

    fkr_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Circular address arithmetic
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                       AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign addr_inc  = (addr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : addr_reg + AW'(1);
    assign head_inc  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Position tests against the current count
    assign last_scan = (SW'(idx_reg) + SW'(1)) == SW'(count_reg);
    assign last_move = (SW'(idx_reg) + SW'(2)) == SW'(count_reg);

    // Shared key comparator; a pop always takes the head
    assign hit = (op_reg == fkr_pkg::OP_POP) || (rd_data.key == key_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_key_next    = res_key_reg;
        res_handle_next = res_handle_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        out_handle_next = out_handle_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = fkr_pkg::op_t'(op);
                    key_next        = proc_key;
                    res_key_next    = '0;
                    res_handle_next = '0;
                    res_status_next = fkr_pkg::ST_OK;
                    idx_next        = '0;
                    addr_next       = head_reg;
                    state_next      = S_DONE;
                    case (fkr_pkg::op_t'(op))
                        fkr_pkg::OP_PUSH:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                res_status_next = fkr_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = tail_addr;
                                wr_data.key    = proc_key;
                                wr_data.handle = proc_handle;
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        fkr_pkg::OP_POP, fkr_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fkr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        fkr_pkg::OP_NOP:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // fetch the entry under the scan pointer
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_reg;
                state_next = S_CMP;
            end

            // compare, then take out or move on
            S_CMP:
            begin
                if (hit)
                begin
                    res_key_next    = rd_data.key;
                    res_handle_next = rd_data.handle;
                    if (idx_reg == '0)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                    else if (last_scan)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (last_scan)
                begin
                    res_status_next = fkr_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    addr_next  = addr_inc;
                    state_next = S_RD;
                end
            end

            // close the gap: read the next entry
            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_inc;
                state_next = S_SH_WR;
            end

            // ... and write it one place toward the head
            S_SH_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg;
                wr_data   = rd_data;
                addr_next = addr_inc;
                idx_next  = idx_reg + CW'(1);
                if (last_move)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = res_key_reg;
                    out_handle_next = res_handle_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = fkr_pkg::COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            addr_reg       <= '0;
            idx_reg        <= '0;
            op_reg         <= fkr_pkg::OP_NOP;
            key_reg        <= '0;
            res_key_reg    <= '0;
            res_handle_reg <= '0;
            res_status_reg <= fkr_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_key_reg    <= '0;
            out_handle_reg <= '0;
            out_status_reg <= fkr_pkg::ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            addr_reg       <= addr_next;
            idx_reg        <= idx_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            res_key_reg    <= res_key_next;
            res_handle_reg <= res_handle_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_key_reg    <= out_key_next;
            out_handle_reg <= out_handle_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_handle  = out_handle_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

endmodule

@@ sv/fkr_store.sv @@
// ----------------------------------------------------------------------------
// fkr_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fkr_store #(
    parameter int QUEUE_DEPTH = fkr_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  fkr_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output fkr_pkg::entry_t rd_data
);

    fkr_pkg::entry_t mem [QUEUE_DEPTH];
    fkr_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data valid the cycle after the request
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/fkr_checker.sv @@
// ----------------------------------------------------------------------------
// fkr_port_checks
// Port-level checks for the keyed-removal process queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fkr_port_checks #(
    parameter int QUEUE_DEPTH = fkr_pkg::QUEUE_DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [fkr_pkg::KEY_W-1:0]     out_key,
    input logic [fkr_pkg::HANDLE_W-1:0]  out_handle,
    input logic [fkr_pkg::STATUS_W-1:0]  status,
    input logic [fkr_pkg::COUNT_W-1:0]   entry_count
);

    // Stalled result holds its payload
    `ASSERT_CLK(a_out_hold,
        out_valid && out_stall |=> $stable(out_key) && $stable(out_handle)
            && $stable(status) && $stable(entry_count),
        "output payload changed while stalled")

    // Block goes busy right after taking a transfer
    `ASSERT_CLK(a_busy_after_accept,
        in_valid && !in_stall |=> in_stall,
        "input not stalled after a transfer")

    // Failed operations return no entry
    `ASSERT_NEVER(a_fail_no_entry,
        out_valid && (status != fkr_pkg::ST_OK)
            && ((out_key != '0) || (out_handle != '0)),
        "entry returned with a failure status")

    // Full status only with the queue at capacity
    `ASSERT_CLK(a_full_count,
        out_valid && (status == fkr_pkg::ST_FULL)
            |-> entry_count == fkr_pkg::COUNT_W'(QUEUE_DEPTH),
        "full status with spare room")

endmodule

bind fifo_with_keyed_removal fkr_port_checks #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fkr_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .out_handle  (out_handle),
    .status      (status),
    .entry_count (entry_count)
);
